[sv/mwnm_pkg.sv]
package mwnm_pkg;

  // Store geometry
  localparam int unsigned PatternSlots = 64;
  localparam int unsigned FillW        = $clog2(PatternSlots + 1);

  // Wildcard characters
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChNul   = 8'h00;

  // Input operations
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_NAME   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic       upd;    // rewrite the active bit this cycle
    logic       load;   // seed with pattern starts
    logic       step;   // advance by one name character
    logic [7:0] ch;     // name character or store write data
  } cell_ctrl_t;

  // Signals handed from one cell to the next
  typedef struct packed {
    logic zero;   // this slot holds a pattern terminator
    logic fwd;    // this slot consumed the character, next slot goes live
    logic carry;  // slot going active is optional, next slot also active (empty match)
  } cell_link_t;

  // ASCII upper case to lower case
  function automatic logic [7:0] fold_case(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[sv/mwnm_in_if.sv]
interface mwnm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink (input valid, input op, input ch, output ready);
endinterface

[sv/mwnm_out_if.sv]
interface mwnm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflowed;

  modport source (output valid, output matched, output overflowed, input ready);
  modport sink (input valid, input matched, input overflowed, output ready);
endinterface

[sv/multi_wildcard_name_matcher_core.sv]
// Wildcard name matcher. Patterns are appended one byte per transaction (a zero
// ends a pattern, a zero at a pattern start closes the list); name bytes are
// then streamed and an end-of-name transaction returns one result with the
// match flag and the sticky overflow flag. A new transaction is accepted every
// cycle; the result appears on the output register the cycle after the
// end-of-name transaction, and input ready only drops while that register
// holds a result that is not taken. Each of the 64 slots is a cell holding
// one pattern byte and one active bit; all cells update together per name
// byte, and the empty match of '*' and '?' ripples through the row as a carry
// chain, which sets the cycle time.
module multi_wildcard_name_matcher_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  mwnm_in_if.sink   in_i,
  mwnm_out_if.source out_o
);

  localparam int unsigned Slots = mwnm_pkg::PatternSlots;
  localparam int unsigned FillW = mwnm_pkg::FillW;

  logic [FillW-1:0]     fill_q, fill_d;
  logic                 closed_q, closed_d;
  logic                 ovf_q, ovf_d;
  logic                 last_zero_q, last_zero_d;
  logic                 out_valid_q, out_valid_d;
  logic                 matched_q, matched_d;
  logic                 ovf_out_q, ovf_out_d;

  logic                 acc;
  mwnm_pkg::op_e        op;
  logic                 at_start;
  logic                 closing;
  logic                 store_write;
  logic                 has_room;
  mwnm_pkg::cell_ctrl_t ctrl;
  logic [Slots-1:0]     in_use;
  logic [Slots-1:0]     we;
  logic [Slots-1:0]     accept;
  mwnm_pkg::cell_link_t link [Slots+1];

  // Handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign op         = mwnm_pkg::op_e'(in_i.op);

  // Append decode
  assign at_start    = (fill_q == '0) || last_zero_q;
  assign closing     = acc && (op == mwnm_pkg::OP_APPEND) && !closed_q &&
                       (in_i.ch == mwnm_pkg::ChNul) && at_start;
  assign store_write = acc && (op == mwnm_pkg::OP_APPEND) && !closed_q && !closing;
  assign has_room    = (fill_q < FillW'(Slots));

  // Cell control
  assign ctrl.upd  = acc && ((op != mwnm_pkg::OP_APPEND) || closing);
  assign ctrl.load = closing || (acc && (op == mwnm_pkg::OP_END) && closed_q);
  assign ctrl.step = (op == mwnm_pkg::OP_NAME);
  assign ctrl.ch   = in_i.ch;

  // Slot 0 always counts as a pattern start
  assign link[0].zero  = 1'b1;
  assign link[0].fwd   = 1'b0;
  assign link[0].carry = 1'b0;

  // Row of cells
  for (genvar i = 0; i < Slots; i++) begin : g_cell
    assign in_use[i] = (fill_q > FillW'(i));
    if (i == Slots - 1) begin : g_last
      assign we[i] = store_write &&
                     ((has_room && (fill_q == FillW'(i))) ||
                      (!has_room && (in_i.ch == mwnm_pkg::ChNul)));
    end else begin : g_mid
      assign we[i] = store_write && has_room && (fill_q == FillW'(i));
    end

    mwnm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .in_use_i (in_use[i]),
      .we_i     (we[i]),
      .link_i   (link[i]),
      .link_o   (link[i+1]),
      .accept_o (accept[i])
    );
  end

  // List and flag state
  always_comb begin
    fill_d      = fill_q;
    closed_d    = closed_q;
    ovf_d       = ovf_q;
    last_zero_d = last_zero_q;
    if (acc && (op == mwnm_pkg::OP_CLEAR)) begin
      fill_d   = '0;
      closed_d = 1'b0;
      ovf_d    = 1'b0;
    end else if (closing) begin
      closed_d = 1'b1;
    end else if (store_write) begin
      if (has_room) begin
        fill_d      = fill_q + FillW'(1);
        last_zero_d = (in_i.ch == mwnm_pkg::ChNul);
      end else begin
        ovf_d = 1'b1;
        if (in_i.ch == mwnm_pkg::ChNul) begin
          last_zero_d = 1'b1;
        end
      end
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    ovf_out_d   = ovf_out_q;
    if (acc && (op == mwnm_pkg::OP_END)) begin
      out_valid_d = 1'b1;
      matched_d   = |accept;
      ovf_out_d   = ovf_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      closed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      last_zero_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      closed_q    <= closed_d;
      ovf_q       <= ovf_d;
      last_zero_q <= last_zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    ovf_out_q <= ovf_out_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.matched    = matched_q;
  assign out_o.overflowed = ovf_out_q;

endmodule

[sv/mwnm_cell.sv]
module mwnm_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mwnm_pkg::cell_ctrl_t   ctrl_i,
  input  logic                   in_use_i,
  input  logic                   we_i,
  input  mwnm_pkg::cell_link_t   link_i,
  output mwnm_pkg::cell_link_t   link_o,
  output logic                   accept_o
);

  logic [7:0] byte_q;
  logic       act_q;
  logic       act_d;
  logic       is_zero;
  logic       is_star;
  logic       is_opt;
  logic       live;
  logic       lit_hit;
  logic       seed;
  logic       nxt;
  logic       base;
  logic       closed;

  // Decode the stored pattern character
  assign is_zero = (byte_q == mwnm_pkg::ChNul);
  assign is_star = (byte_q == mwnm_pkg::ChStar);
  assign is_opt  = is_star || (byte_q == mwnm_pkg::ChQuest);
  assign live    = act_q && in_use_i;
  assign lit_hit = (byte_q == mwnm_pkg::ChQuest) ||
                   (mwnm_pkg::fold_case(byte_q) == mwnm_pkg::fold_case(ctrl_i.ch));

  // Seed: slot follows a terminator (or is slot 0)
  assign seed = in_use_i && link_i.zero;
  // Step: star holds itself, a matched literal or '?' moves to the next slot
  assign nxt  = in_use_i && ((live && is_star) || link_i.fwd);
  assign base = (ctrl_i.load && seed) || (ctrl_i.step && nxt);

  // Empty-match closure ripples like a carry through runs of '*' and '?'
  assign closed       = base || (link_i.carry && in_use_i);
  assign link_o.carry = closed && in_use_i && is_opt;
  assign link_o.fwd   = live && !is_zero && !is_star && lit_hit;
  assign link_o.zero  = is_zero;

  assign act_d    = ctrl_i.upd ? closed : act_q;
  assign accept_o = live && is_zero;

  // Active bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  // Pattern character, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      byte_q <= ctrl_i.ch;
    end
  end

endmodule

[sv/mwnm_checker.sv]
module mwnm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_op_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_matched_i,
  input logic       out_overflowed_i
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // A new result only follows an accepted end-of-name transaction
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (!$past(out_valid_i) || $past(out_acc))) |->
      $past(in_acc && (in_op_i == mwnm_pkg::OP_END)))
    else $error("result without end-of-name transaction");

  // Input is held off while a result waits
  a_stall_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input accepted while result stalled");

  // Clear followed at once by end-of-name reports no overflow and no match
  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((in_acc && (in_op_i == mwnm_pkg::OP_CLEAR)) ##1
     (in_acc && (in_op_i == mwnm_pkg::OP_END))) |=>
      (!out_overflowed_i && !out_matched_i))
    else $error("stale state after clear");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_matched_i) && $stable(out_overflowed_i)))
    else $error("stalled result changed");

endmodule

bind multi_wildcard_name_matcher_core mwnm_checker u_mwnm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_op_i          (in_i.op),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_matched_i    (out_o.matched),
  .out_overflowed_i (out_o.overflowed)
);
